FILE: rtl/sha256_pkg.sv
// SHA-256 package: round constants, initial hash values and round functions.
// Used by every module of the hash engine; no dependencies.
`default_nettype none
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [3:0] LenPos  = 4'd14;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // Request from the word sequencer to the compression core.
  typedef struct packed {
    logic  wr;
    logic [3:0] addr;
    word_t data;
    logic  start;
  } blk_req_t;

endpackage
`default_nettype wire

FILE: rtl/sha256_if.sv
// Valid/ready channel interfaces for the SHA-256 engine.
// Stands alone; the payload widths are written out here.
`default_nettype none
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;
  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: rtl/sha256_hash_engine_top.sv
// Top level of the SHA-256 engine: word sequencer plus compression core.
// Depends on sha256_pkg, sha256_if, sha256_seq and sha256_core.
//
// Message words enter one per transaction and go straight into the block
// memory; the sixteenth word of a block starts a compression, during which
// input is held off. A compression loads the schedule window from the block
// memory, runs the 64 rounds at one per cycle and then adds the working
// variables into the hash memory word by word. A last word pads the message
// at one padding word per cycle while no compression runs, which may take
// one extra block, then the eight digest words leave as eight transactions,
// each read from the hash memory through a registered port and held valid
// until the receiver takes it.
`default_nettype none
module sha256_hash_engine_top (
  input wire logic     clk,
  input wire logic     rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  blk_req_t   req;
  logic       busy;
  logic       hrd_en;
  logic [2:0] hrd_addr;
  word_t      hrd_data;
  logic       hinit;

  sha256_seq u_seq (
    .clk, .rst, .in_ch, .out_ch, .req, .busy,
    .hrd_en, .hrd_addr, .hrd_data, .hinit
  );

  sha256_core u_core (
    .clk, .rst, .req, .busy, .hrd_en, .hrd_addr, .hrd_data, .hinit
  );
endmodule
`default_nettype wire

FILE: rtl/sha256_core.sv
// Compression core: message block memory, rolling schedule, hash memory and round loop.
// Depends on sha256_pkg.
`default_nettype none
module sha256_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sha256_pkg::blk_req_t req,
  output logic                      busy,
  input  wire logic                 hrd_en,
  input  wire logic [2:0]           hrd_addr,
  output sha256_pkg::word_t         hrd_data,
  input  wire logic                 hinit
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_RUN, S_ADD, S_ADDW} state_t;

  state_t      state;
  word_t       mem [16];
  word_t       hmem [8];
  logic [7:0]  hvalid;   // cleared entries read as the initial hash
  word_t       v [8];
  logic [6:0]  t;
  logic [3:0]  cnt;
  word_t       w15, w2, w7, w16, wcur;
  word_t       hrd_q;
  logic [2:0]  hidx;

  // Schedule words come from the memory through a small register window:
  // a 16-deep shift line loaded from the block memory, which is left untouched.
  word_t win [16];
  word_t wnew, t1, t2;

  always_comb begin
    w15  = win[1];
    w2   = win[14];
    w7   = win[9];
    w16  = win[0];
    wnew = w16 + ssig0(w15) + w7 + ssig1(w2);
    wcur = (t < 7'd16) ? win[t[3:0]] : wnew;
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t[5:0]] + wcur;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign busy     = (state != S_IDLE);
  assign hrd_data = hrd_q;
  assign hidx     = hrd_en ? hrd_addr : cnt[2:0];

  always_ff @(posedge clk) begin
    if (req.wr) mem[req.addr] <= req.data;
    hrd_q <= hvalid[hidx] ? hmem[hidx] : InitHash[hidx];
    if (rst || hinit) begin
      hvalid <= '0;
    end else if (state == S_ADDW) begin
      hmem[cnt[2:0]]   <= hrd_q + v[cnt[2:0]];
      hvalid[cnt[2:0]] <= 1'b1;
    end
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      t     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            state <= S_LOAD;
            cnt   <= '0;
          end
        end
        S_LOAD: begin
          // One memory word per cycle into the window; the first eight also load a hash word into v.
          win[cnt] <= mem[cnt];
          if (cnt < 4'd8) v[cnt[2:0]] <= hvalid[cnt[2:0]] ? hmem[cnt[2:0]]
                                                         : InitHash[cnt[2:0]];
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_RUN;
            t     <= '0;
          end
        end
        S_RUN: begin
          if (t >= 7'd16) begin
            for (int i = 0; i < 15; i++) win[i] <= win[i+1];
            win[15] <= wnew;
          end
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          t <= t + 7'd1;
          if (t == 7'd63) begin
            state <= S_ADD;
            cnt   <= '0;
          end
        end
        S_ADD: state <= S_ADDW;   // hash read issued, data next cycle
        S_ADDW: begin
          cnt   <= cnt + 4'd1;
          state <= (cnt[2:0] == 3'd7) ? S_IDLE : S_ADD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sha256_seq.sv
// Word sequencer: takes message words, pads, counts length, emits the digest.
// Depends on sha256_pkg and sha256_if.
`default_nettype none
module sha256_seq (
  input  wire logic        clk,
  input  wire logic        rst,
  sha256_in_if.sink        in_ch,
  sha256_out_if.source     out_ch,
  output sha256_pkg::blk_req_t req,
  input  wire logic        busy,
  output logic             hrd_en,
  output logic [2:0]       hrd_addr,
  input  wire sha256_pkg::word_t hrd_data,
  output logic             hinit
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {S_IN, S_PAD, S_WAIT, S_RD, S_RDW, S_OUT} state_t;

  state_t      state;
  logic [3:0]  pos;
  logic [63:0] bits;
  logic [1:0]  pad_ph;      // 0 zeros then high length, 2 low length
  logic        need_80;
  logic [2:0]  oidx;
  word_t       masked;
  logic [2:0]  cnt;
  logic [5:0]  sh;

  always_comb begin
    cnt = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
    sh  = 6'(5'd24 - {cnt[1:0], 3'b000});
    masked = (cnt == 3'd0) ? word_t'(0)
           : (in_ch.data_word & ~(32'hffffffff >> {cnt, 3'b000}));
  end

  assign in_ch.ready = (state == S_IN) && !busy && !rst;

  always_ff @(posedge clk) begin
    req.wr    <= 1'b0;
    req.start <= 1'b0;
    hinit     <= 1'b0;
    if (rst) begin
      state        <= S_IN;
      pos          <= '0;
      bits         <= '0;
      out_ch.valid <= 1'b0;
      hrd_en       <= 1'b0;
    end else begin
      unique case (state)
        S_IN: begin
          if (in_ch.valid && in_ch.ready) begin
            req.wr   <= 1'b1;
            req.addr <= pos;
            pos      <= pos + 4'd1;
            req.start <= (pos == 4'd15);
            if (!in_ch.last) begin
              req.data <= in_ch.data_word;
              bits     <= bits + 64'd32;
            end else begin
              bits <= bits + 64'({cnt, 3'b000});
              if (cnt == 3'd4) begin
                req.data <= in_ch.data_word;
                need_80  <= 1'b1;
              end else begin
                req.data <= masked | (word_t'(PadByte) << sh);
                need_80  <= 1'b0;
              end
              pad_ph <= 2'd0;
              state  <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (!busy && !req.start) begin
            req.wr   <= 1'b1;
            req.addr <= pos;
            pos      <= pos + 4'd1;
            req.start <= (pos == 4'd15);
            if (need_80) begin
              req.data <= {PadByte, 24'd0};
              need_80  <= 1'b0;
            end else if (pad_ph == 2'd0) begin
              if (pos == LenPos) begin
                req.data <= bits[63:32];
                pad_ph   <= 2'd2;
              end else begin
                req.data <= '0;
              end
            end else begin
              req.data <= bits[31:0];
              state    <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (!busy && !req.start) begin
            hrd_en   <= 1'b1;
            hrd_addr <= '0;
            oidx     <= '0;
            state    <= S_RD;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          out_ch.valid       <= 1'b1;
          out_ch.digest_word <= hrd_data;
          out_ch.word_index  <= oidx;
          out_ch.last_word   <= (oidx == 3'd7);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            oidx     <= oidx + 3'd1;
            hrd_addr <= hrd_addr + 3'd1;
            if (oidx == 3'd7) begin
              hrd_en <= 1'b0;
              hinit  <= 1'b1;
              bits   <= '0;
              pos    <= '0;
              state  <= S_IN;
            end else begin
              state <= S_RD;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sha256_chk.sv
// Port checker for the SHA-256 engine and its bind to the top level.
// Depends on sha256_if.
`default_nettype none
module sha256_chk (
  input wire logic clk,
  input wire logic rst,
  sha256_in_if.sink in_ch,
  sha256_out_if.source out_ch
);
  logic [2:0] exp_idx;

  // Index that the next digest transaction should carry.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      exp_idx <= out_ch.word_index + 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word))
    else $error("digest word changed while stalled");
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while digest pending");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd7)))
    else $error("last_word mismatch");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.word_index == exp_idx))
    else $error("digest word index out of sequence");
endmodule

bind sha256_hash_engine_top sha256_chk u_chk (.clk, .rst, .in_ch, .out_ch);
`default_nettype wire

FILE: verif/sha256_tb_checker.sv
// Digest checker for the SHA-256 engine: watches both channels, predicts digests.
// Depends on sha256_pkg (round constants, initial hash) and sha256_if.
`timescale 1ns / 1ps
`default_nettype none
module sha256_tb_checker (
  input wire logic clk,
  input wire logic rst,
  sha256_in_if     in_mon,
  sha256_out_if    out_mon,
  output int       fail_count,
  output int       pending_count,
  output int       digest_count
);
  import sha256_pkg::*;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } digest_item_t;

  word_t        msg_win [16];
  word_t        hash_acc [8];
  logic [63:0]  msg_bits;
  logic [3:0]   fill_pos;
  digest_item_t digest_queue [$];
  int           mismatches;

  function automatic word_t rot(input word_t x, input int n);
    rot = (x >> n) | (x << (32 - n));
  endfunction

  task automatic run_block();
    word_t v [8];
    word_t sched_a, sched_b, t1, t2, w;
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        sched_a = msg_win[(t - 15) & 15];
        sched_b = msg_win[(t - 2) & 15];
        msg_win[t & 15] = msg_win[t & 15]
          + (rot(sched_a, 7) ^ rot(sched_a, 18) ^ (sched_a >> 3))
          + msg_win[(t - 7) & 15]
          + (rot(sched_b, 17) ^ rot(sched_b, 19) ^ (sched_b >> 10));
      end
      w = msg_win[t & 15];
      t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w;
      t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
  endtask

  task automatic append_word(input word_t w);
    msg_win[fill_pos] = w;
    if (fill_pos == 4'd15) run_block();
    fill_pos = fill_pos + 4'd1;
  endtask

  task automatic absorb_word(input word_t data, input logic [2:0] nbytes, input logic fin);
    int    cnt;
    word_t keep;
    digest_item_t d;
    if (!fin) begin
      msg_bits += 64'd32;
      append_word(data);
      return;
    end
    cnt = (nbytes > 3'd4) ? 4 : int'(nbytes);
    msg_bits += 64'(cnt * 8);
    if (cnt == 4) begin
      append_word(data);
      append_word({PadByte, 24'h0});
    end else begin
      keep = (cnt == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * cnt));
      append_word((data & keep) | (word_t'(PadByte) << (24 - 8 * cnt)));
    end
    if (fill_pos > LenPos) while (fill_pos != 4'd0) append_word(32'h0);
    while (fill_pos < LenPos) append_word(32'h0);
    append_word(msg_bits[63:32]);
    append_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hash_acc[i];
      d.word_index = 3'(i);
      d.last_word = (i == 7);
      digest_queue.push_back(d);
      hash_acc[i] = InitHash[i];
    end
    msg_bits = '0;
    fill_pos = '0;
  endtask

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch in %s: expected %h, got %h", what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    digest_item_t exp_d;
    if (rst) begin
      for (int i = 0; i < 8; i++) hash_acc[i] = InitHash[i];
      msg_bits = '0;
      fill_pos = '0;
      digest_queue.delete();
      mismatches = 0;
      digest_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        absorb_word(in_mon.data_word, in_mon.byte_count, in_mon.last);
      if (out_mon.valid && out_mon.ready) begin
        digest_count++;
        if (digest_queue.size() == 0) begin
          report("unexpected digest transaction", 32'h0, out_mon.digest_word);
        end else begin
          exp_d = digest_queue.pop_front();
          if (out_mon.digest_word !== exp_d.digest_word)
            report("digest_word", exp_d.digest_word, out_mon.digest_word);
          if (out_mon.word_index !== exp_d.word_index)
            report("word_index", 32'(exp_d.word_index), 32'(out_mon.word_index));
          if (out_mon.last_word !== exp_d.last_word)
            report("last_word", 32'(exp_d.last_word), 32'(out_mon.last_word));
        end
      end
    end
    pending_count <= digest_queue.size();
    fail_count <= mismatches;
  end

endmodule
`default_nettype wire

FILE: verif/tb_sha256_hash_engine_top.sv
// Testbench top for the SHA-256 engine: clock, reset, message stimulus and verdict.
// Depends on sha256_pkg, sha256_if, the engine RTL and sha256_tb_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_hash_engine_top;

  localparam int CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_count, digest_count;
  int   cycle_count = 0;
  int   msg_count = 0;
  int   word_count = 0;
  logic hold_off = 1'b0;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_hash_engine_top uut (.clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  sha256_tb_checker chk (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count), .digest_count(digest_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Digest receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (1500) @(negedge clk);
        hold_off = 1'b0;
      end
      out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes, input logic fin,
                           input bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_word <= data;
    in_ch.byte_count <= nbytes;
    in_ch.last <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    word_count++;
    if (fin) msg_count++;
  endtask

  // A message of full words followed by a last word with the given byte count.
  task automatic send_message(input int full_words, input logic [2:0] tail_bytes,
                              input bit all_ones, input bit no_gap);
    for (int i = 0; i < full_words; i++)
      send_word(all_ones ? 32'hffffffff : $urandom(), 3'($urandom_range(0, 7)), 1'b0, no_gap);
    send_word(all_ones ? 32'hffffffff : $urandom(), tail_bytes, 1'b1, no_gap);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    int words;
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.byte_count = '0;
    in_ch.last = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty message, every tail length, padding that spills into a
    // second block, an all-ones block and byte counts above four on the last word.
    send_word(32'h0, 3'd0, 1'b1, 1'b0);
    send_word(32'hffffffff, 3'd0, 1'b1, 1'b0);
    for (int b = 1; b <= 4; b++) send_message(0, 3'(b), 1'b0, 1'b0);
    send_message(13, 3'd3, 1'b1, 1'b0);
    send_message(15, 3'd4, 1'b0, 1'b0);
    send_message(1, 3'd7, 1'b1, 1'b0);
    send_message(0, 3'd5, 1'b0, 1'b0);
    drain();

    // Long receiver hold-off while the sender keeps offering two messages.
    hold_off = 1'b1;
    send_message(2, 3'd2, 1'b0, 1'b1);
    send_message(20, 3'd4, 1'b0, 1'b1);
    drain();

    while (word_count < 360) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: words = $urandom_range(0, 4);
        4, 5, 6:    words = $urandom_range(5, 16);
        7, 8:       words = $urandom_range(12, 15);
        default:    words = $urandom_range(17, 33);
      endcase
      send_message(words, 3'($urandom_range(0, 7)), $urandom_range(0, 15) == 0, 1'b0);
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();

    repeat (300) @(negedge clk);
    $display("Hashed %0d messages from %0d words, %0d digest words checked.",
             msg_count, word_count, digest_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/sha256_pkg.sv
rtl/sha256_if.sv
rtl/sha256_core.sv
rtl/sha256_seq.sv
rtl/sha256_hash_engine_top.sv
rtl/sha256_chk.sv
verif/sha256_tb_checker.sv
verif/tb_sha256_hash_engine_top.sv
